[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of the point generator.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is held
`define ACG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define ACG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/acg_pkg.sv]
// Shared types, constants and the quarter-wave sine table of the astroid point generator.
// No dependencies; every other module and interface imports it.
package acg_pkg;

  // Phase and table geometry
  localparam int PHASE_BITS    = 16;
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int HALF_ENTRIES  = TABLE_ENTRIES / 2;
  localparam int QTR_ENTRIES   = TABLE_ENTRIES / 4;
  localparam int QIDX_W        = $clog2(QTR_ENTRIES + 1);

  // Field widths
  localparam int POS_W      = 24;
  localparam int STEP_W     = 16;
  localparam int SIN_W      = 16;
  localparam int TERM_W     = POS_W + 1;
  localparam int SUM_W      = POS_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
  localparam int POS_MIN = -(1 << (POS_W - 1));

  // Decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Table generation constants (pi and one in Q30)
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned AMP     = 64'd32767;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic [PHASE_BITS-1:0]    phase_t;
  typedef logic [STEP_W-1:0]        step_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [SIN_W-1:0]  sample_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ORIGIN_Z     = 3'd2,
    REG_CURVE_RADIUS = 3'd3,
    REG_ANGLE_STEP   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    pos_t  origin_x;
    pos_t  origin_y;
    pos_t  origin_z;
    pos_t  curve_radius;
    step_t angle_step;
  } cfg_t;

  // One queued point: table index of its phase
  typedef struct packed {
    logic valid;
    idx_t idx;
  } entry_t;

  typedef logic [SIN_W-1:0] qsin_tab_t [QTR_ENTRIES+1];

  // Unsigned quotient by shift and subtract; used only while building the table
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter sine, round(32767*sin), by an eleven-term series in Q30
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint unsigned e;
    longint          sum;
    for (int k = 0; k <= QTR_ENTRIES; k++) begin
      x    = (64'd2 * PI_Q30 * longint'(k)) / TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = udiv((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = longint'(sum);
      if (v > ONE_Q30) begin
        v = ONE_Q30;
      end
      e = (v * AMP + (ONE_Q30 >> 1)) >> 30;
      if (e > AMP) begin
        e = AMP;
      end
      tab[k] = SIN_W'(e);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

endpackage

[hw/rtl/acg_if.sv]
// Valid/ready channel interfaces for the input and result beats of the point generator.
// Depends on acg_pkg for the payload types.
interface acg_in_if import acg_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface acg_out_if import acg_pkg::*; ();
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;
  logic clipped;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output clipped,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input clipped,
                  output ready);
endinterface

[hw/rtl/acg_front.sv]
// Front end: takes input beats, keeps the phase accumulator and queues table indexes.
// Depends on acg_pkg and acg_in_if.
module acg_front import acg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  acg_in_if.sink       in_i,
  input  step_t        angle_step_i,
  input  logic         q_full_i,
  output entry_t       push_o
);

  phase_t phase_q;
  phase_t phase_d;
  phase_t phase_cur;
  logic   accept;
  logic [PHASE_BITS+IDX_W-1:0] phase_scaled;

  // Take a beat whenever the queue has room
  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // Zero the phase first on restart
  assign phase_cur = in_i.restart ? '0 : phase_q;

  // Scale the phase to a table index: phase * entries / 2^PHASE_BITS
  assign phase_scaled = {phase_cur, {IDX_W{1'b0}}};

  always_comb begin
    push_o.valid = accept;
    push_o.idx   = phase_scaled[PHASE_BITS +: IDX_W];
  end

  // Advance by the step after each accepted beat, wrapping at one turn
  assign phase_d = accept ? phase_t'(phase_cur + PHASE_BITS'(angle_step_i)) : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

[hw/rtl/acg_queue.sv]
// Short FIFO of table indexes between the front end and the arithmetic back end.
// Depends on acg_pkg.
module acg_queue import acg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t push_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t head_o
);

  idx_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;
  logic              do_pop;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.idx   = mem_q[rptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i.valid && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i.valid) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wptr_q] <= push_i.idx;
    end
  end

endmodule

[hw/rtl/acg_back.sv]
// Back end: table lookup, square, cube, radius scaling and saturating add, one stage each.
// Depends on acg_pkg and acg_out_if.
module acg_back import acg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  entry_t        head_i,
  output logic          pop_o,
  acg_out_if.source     out_o
);

  logic    en;
  logic    va_q, vb_q, vc_q, vd_q, out_valid_q;
  sample_t sin_d, cos_d;
  sample_t sin_a_q, cos_a_q;
  sample_t sin_b_q, cos_b_q, sin2_b_q, cos2_b_q;
  sample_t sin3_c_q, cos3_c_q;
  term_t   ty_d_q, tx_d_q;
  logic signed [2*SIN_W-1:0] sin2_d, cos2_d, sin3_d, cos3_d;
  logic signed [POS_W+SIN_W-1:0] tx_d, ty_d;
  sum_t    sum_x, sum_y;
  pos_t    pos_x_d, pos_y_d;
  logic    clip_x, clip_y;
  pos_t    pos_x_q, pos_y_q, pos_z_q;
  logic    clipped_q;
  idx_t    cos_idx;

  // Signed sine read from the quarter-wave table
  function automatic sample_t sine_at(idx_t idx);
    logic [QIDX_W-1:0] lo;
    logic [QIDX_W-1:0] k;
    sample_t           mag;
    lo = idx[QIDX_W-1:0];
    k  = (lo > QIDX_W'(QTR_ENTRIES)) ? QIDX_W'(QIDX_W'(0) - lo) : lo;
    mag = sample_t'(QSIN[k]);
    return idx[IDX_W-1] ? sample_t'(-mag) : mag;
  endfunction

  // Move the whole pipeline when the output register is free or taken
  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = en && head_i.valid;

  // Stage A: sine and cosine (a quarter turn ahead)
  assign cos_idx = idx_t'(head_i.idx + idx_t'(QTR_ENTRIES));
  assign sin_d   = sine_at(head_i.idx);
  assign cos_d   = sine_at(cos_idx);

  // Stage B: squares, floor by 2^15
  assign sin2_d = sin_a_q * sin_a_q;
  assign cos2_d = cos_a_q * cos_a_q;

  // Stage C: cubes, floor by 2^15
  assign sin3_d = sin2_b_q * sin_b_q;
  assign cos3_d = cos2_b_q * cos_b_q;

  // Stage D: scale by the radius, floor by 2^15
  assign tx_d = cfg_i.curve_radius * cos3_c_q;
  assign ty_d = cfg_i.curve_radius * sin3_c_q;

  // Stage E: add the origin and clamp to the position range
  assign sum_x = $signed({{2{cfg_i.origin_x[POS_W-1]}}, cfg_i.origin_x})
               + $signed({tx_d_q[TERM_W-1], tx_d_q});
  assign sum_y = $signed({{2{cfg_i.origin_y[POS_W-1]}}, cfg_i.origin_y})
               + $signed({ty_d_q[TERM_W-1], ty_d_q});

  always_comb begin
    clip_x  = 1'b0;
    clip_y  = 1'b0;
    pos_x_d = sum_x[POS_W-1:0];
    pos_y_d = sum_y[POS_W-1:0];
    if (sum_x > POS_MAX) begin
      clip_x  = 1'b1;
      pos_x_d = pos_t'(POS_MAX);
    end else if (sum_x < POS_MIN) begin
      clip_x  = 1'b1;
      pos_x_d = pos_t'(POS_MIN);
    end
    if (sum_y > POS_MAX) begin
      clip_y  = 1'b1;
      pos_y_d = pos_t'(POS_MAX);
    end else if (sum_y < POS_MIN) begin
      clip_y  = 1'b1;
      pos_y_d = pos_t'(POS_MIN);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= head_i.valid;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      out_valid_q <= vd_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      sin_a_q   <= sin_d;
      cos_a_q   <= cos_d;
      sin_b_q   <= sin_a_q;
      cos_b_q   <= cos_a_q;
      sin2_b_q  <= sin2_d[SIN_W+14:15];
      cos2_b_q  <= cos2_d[SIN_W+14:15];
      sin3_c_q  <= sin3_d[SIN_W+14:15];
      cos3_c_q  <= cos3_d[SIN_W+14:15];
      tx_d_q    <= tx_d[TERM_W+14:15];
      ty_d_q    <= ty_d[TERM_W+14:15];
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      pos_z_q   <= cfg_i.origin_z;
      clipped_q <= clip_x || clip_y;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pos_x   = pos_x_q;
  assign out_o.pos_y   = pos_y_q;
  assign out_o.pos_z   = pos_z_q;
  assign out_o.clipped = clipped_q;

endmodule

[hw/rtl/astroid_curve_generator_top.sv]
// Astroid point generator: one point per clock sustained while each result beat is
// taken, set by the single phase add per beat in the front end and the five-stage
// pipeline in the back end.
// A four-entry queue lets the front keep taking beats while the back stalls.
// Reset clears phase, configuration, queue and stage valid bits at once; no clearing pass.
// Depends on acg_pkg, acg_if, acg_front, acg_queue and acg_back.
module astroid_curve_generator_top import acg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  acg_in_if.sink                in_i,
  acg_out_if.source             out_o
);

  cfg_t   cfg_q;
  entry_t push;
  entry_t head;
  logic   q_full;
  logic   pop;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X:     cfg_q.origin_x     <= pos_t'(cfg_data_i);
        REG_ORIGIN_Y:     cfg_q.origin_y     <= pos_t'(cfg_data_i);
        REG_ORIGIN_Z:     cfg_q.origin_z     <= pos_t'(cfg_data_i);
        REG_CURVE_RADIUS: cfg_q.curve_radius <= pos_t'(cfg_data_i);
        REG_ANGLE_STEP:   cfg_q.angle_step   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  acg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .angle_step_i (cfg_q.angle_step),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  acg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  acg_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

[hw/rtl/acg_checker.sv]
// Port-level checks of the astroid point generator, bound to its top level.
// Depends on acg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module acg_checker import acg_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input pos_t out_pos_x_i,
  input pos_t out_pos_y_i,
  input pos_t out_pos_z_i,
  input logic out_clipped_i
);

  // A stalled result beat holds
  `ACG_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pos_x_i) && $stable(out_pos_y_i) && $stable(out_pos_z_i) && $stable(out_clipped_i), "result beat changed while stalled")

  // A clipped point sits on a range limit in x or y
  `ACG_ASSERT(a_clip_limit, out_valid_i && out_clipped_i |-> out_pos_x_i == POS_MAX || out_pos_x_i == POS_MIN || out_pos_y_i == POS_MAX || out_pos_y_i == POS_MIN, "clipped point not at a limit")

  // No result beat once reset has been seen at an edge
  `ACG_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_i, "result valid during reset")

endmodule

bind astroid_curve_generator_top acg_checker u_acg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_pos_x_i   (out_o.pos_x),
  .out_pos_y_i   (out_o.pos_y),
  .out_pos_z_i   (out_o.pos_z),
  .out_clipped_i (out_o.clipped)
);
